### rtl/deadline_timer_scheduler_top_macros.svh
// Assertion macros for the timer scheduler checker.
`ifndef DEADLINE_TIMER_SCHEDULER_TOP_MACROS_SVH
`define DEADLINE_TIMER_SCHEDULER_TOP_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define DTS_ASSERT_ALWAYS(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("%m: property failed");

// Consequent must hold in the cycle after the antecedent.
`define DTS_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("%m: next-cycle property failed");

// A stalled item keeps valid high and its payload steady.
`define DTS_ASSERT_HOLD(lbl, clk, rst, vld, rdy, data) \
  lbl: assert property (@(posedge clk) disable iff (rst) \
    (vld && !rdy) |=> (vld && $stable(data))) \
    else $error("%m: stalled item not held");

`endif

### rtl/dts_pkg.sv
// Types, constants and codes for the deadline timer scheduler.
package dts_pkg;

  localparam int SLOTS      = 16;
  localparam int IDX_W      = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CNT_W      = $clog2(SLOTS + 1);
  localparam int ID_W       = 4;
  localparam int SEC_W      = 32;
  localparam int ACT_W      = 5;
  localparam int CMP_W      = (IDX_W > ID_W) ? IDX_W : ID_W;
  // only slots reachable through a 4-bit id can ever be armed
  localparam int MAX_ACTIVE = (SLOTS < (1 << ID_W)) ? SLOTS : (1 << ID_W);

  typedef enum logic [1:0] {
    OP_ARM    = 2'd0,
    OP_CANCEL = 2'd1,
    OP_CHECK  = 2'd2,
    OP_CLEAR  = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_ARMED     = 3'd0,
    ST_ZERO      = 3'd1,
    ST_OVERFLOW  = 3'd2,
    ST_CANCELLED = 3'd3,
    ST_INACTIVE  = 3'd4,
    ST_ONCE      = 3'd5,
    ST_LOOPED    = 3'd6,
    ST_NONE      = 3'd7
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_RANK,
    S_EMIT
  } state_t;

  typedef struct packed {
    op_t               operation;
    logic [ID_W-1:0]   timer_id;
    logic [SEC_W-1:0]  period_sec;
    logic              loop_flag;
    logic [SEC_W-1:0]  now_sec;
  } cmd_item_t;

  typedef struct packed {
    logic [ID_W-1:0]   timer_id_res;
    status_t           status;
    logic [ACT_W-1:0]  active_count;
    logic              last;
  } res_item_t;

  // deadline circulating round the ring during ranking
  typedef struct packed {
    logic              due;
    logic [SEC_W-1:0]  end_sec;
    logic [IDX_W-1:0]  idx;
  } pass_t;

  // broadcast from the sequencer to every cell
  typedef struct packed {
    logic              load;
    logic              rank;
    logic              emit;
    logic              arm;
    logic              cancel;
    logic              clear;
    logic [ID_W-1:0]   id;
    logic [SEC_W-1:0]  now;
    logic [SEC_W-1:0]  interval;
    logic              loop_flag;
    logic [SEC_W-1:0]  end_new;
    logic [CNT_W-1:0]  k;
  } cell_ctl_t;

  typedef struct packed {
    logic              sel_active;
    logic              hit;
    logic              loops;
  } cell_stat_t;

endpackage

### rtl/dts_cell.sv
// One timer slot: holds its deadline, ranks itself against the ring, re-arms on expiry.
module dts_cell import dts_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic [IDX_W-1:0]  idx,
  input  cell_ctl_t         ctl,
  input  pass_t             pass_in,
  output pass_t             pass_out,
  output cell_stat_t        stat
);

  logic             active;
  logic             due;
  logic             loop_q;
  logic [SEC_W-1:0] end_sec;
  logic [SEC_W-1:0] ival;
  logic [CNT_W-1:0] rank;
  pass_t            pass;

  logic             match;
  logic             due_now;
  logic             ahead;
  logic [SEC_W:0]   sum;

  assign match   = (CMP_W'(ctl.id) == CMP_W'(idx));
  assign due_now = active && (end_sec <= ctl.now);
  // passing deadline sorts ahead of ours: earlier end, or same end and lower slot
  assign ahead   = pass.due && ((pass.end_sec < end_sec) ||
                   ((pass.end_sec == end_sec) && (pass.idx < idx)));
  assign sum     = {1'b0, end_sec} + {1'b0, ival};

  assign stat.sel_active = match && active;
  assign stat.hit        = due && (rank == ctl.k);
  assign stat.loops      = loop_q && !sum[SEC_W];
  assign pass_out        = pass;

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      due    <= 1'b0;
    end else begin
      if (ctl.clear) begin
        active <= 1'b0;
      end else if (ctl.arm && match) begin
        active <= 1'b1;
      end else if (ctl.cancel && match) begin
        active <= 1'b0;
      end else if (ctl.emit && stat.hit) begin
        active <= stat.loops;
      end
      if (ctl.load) begin
        due <= due_now;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.arm && match) begin
      end_sec <= ctl.end_new;
      ival    <= ctl.interval;
      loop_q  <= ctl.loop_flag;
    end else if (ctl.emit && stat.hit && stat.loops) begin
      end_sec <= sum[SEC_W-1:0];
    end
    if (ctl.load) begin
      rank <= '0;
      pass <= '{due: due_now, end_sec: end_sec, idx: idx};
    end else if (ctl.rank) begin
      pass <= pass_in;
      if (ahead) begin
        rank <= rank + CNT_W'(1);
      end
    end
  end

endmodule

### rtl/deadline_timer_scheduler_top.sv
// Top level of the deadline timer scheduler: sequencer around a ring of slot cells.
//
// Usage notes
// - cmd channel (cmd_valid/cmd_ready/cmd) takes one item per operation: arm,
//   cancel, check expiry or clear all. Every item carries the current second.
// - res channel (res_valid/res_ready/res) returns the results. Each item
//   produces one result, bar a check with expiries, which produces one per
//   expired slot, earliest deadline first, lower slot first on a tie; last
//   marks the final result of an item.
// - Arm, cancel and clear: result registered in the cycle after acceptance; a
//   new item may be taken every cycle while the result register drains.
// - Check: the cells snapshot their due marks on acceptance, then the
//   deadlines circulate once round the ring so each cell counts how many
//   due slots sort ahead of it. Results then leave one per cycle in rank
//   order while the receiver keeps res_ready high.
// - cmd_ready is low during a check and whenever the result register is
//   full and res_ready is low; a stalled receiver simply pauses emission.
// - Reset (rst, synchronous, active high) frees every slot and empties the
//   result register. Slot deadlines are not cleared; they are only read for
//   armed slots.
module deadline_timer_scheduler_top import dts_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       cmd_valid,
  output logic       cmd_ready,
  input  cmd_item_t  cmd,
  output logic       res_valid,
  input  logic       res_ready,
  output res_item_t  res
);

  state_t           state;
  state_t           state_next;
  logic [IDX_W-1:0] step;
  logic [CNT_W-1:0] k;
  logic [CNT_W-1:0] ndue;
  logic [ACT_W-1:0] act_cnt;
  logic [ACT_W-1:0] act_next;

  pass_t            chain [SLOTS];
  cell_stat_t       stat  [SLOTS];
  cell_ctl_t        ctl;

  logic             res_free;
  logic             cmd_fire;
  logic             in_range;
  logic             rank_done;
  logic             last_emit;
  logic             load_res;
  logic             any_sel;
  logic             any_loop;
  logic [ID_W-1:0]  win_id;
  logic [SEC_W:0]   arm_sum;
  res_item_t        res_next;

  // --- handshake ---
  assign res_free  = !res_valid || res_ready;
  assign cmd_ready = (state == S_IDLE) && res_free;
  assign cmd_fire  = cmd_valid && cmd_ready;

  assign in_range  = (int'(cmd.timer_id) < SLOTS);
  assign arm_sum   = {1'b0, cmd.now_sec} + {1'b0, cmd.period_sec};
  assign rank_done = (state == S_RANK) && (step == IDX_W'(SLOTS - 1));
  assign last_emit = (k == ndue - CNT_W'(1));

  // --- ring of slot cells; cell 0 is fed from the far end ---
  for (genvar i = 0; i < SLOTS; i++) begin : g_cell
    dts_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .idx      (IDX_W'(i)),
      .ctl      (ctl),
      .pass_in  (chain[(i + SLOTS - 1) % SLOTS]),
      .pass_out (chain[i]),
      .stat     (stat[i])
    );
  end

  // gather cell reports: at most one cell matches the id or the current rank
  always_comb begin
    any_sel  = 1'b0;
    any_loop = 1'b0;
    win_id   = '0;
    for (int i = 0; i < SLOTS; i++) begin
      any_sel  = any_sel | stat[i].sel_active;
      any_loop = any_loop | (stat[i].hit & stat[i].loops);
      if (stat[i].hit) begin
        win_id = win_id | ID_W'(i);
      end
    end
  end

  // --- next state ---
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (cmd_fire && (cmd.operation == OP_CHECK)) begin
          state_next = S_RANK;
        end
      end
      S_RANK: begin
        if (rank_done) begin
          state_next = S_EMIT;
        end
      end
      S_EMIT: begin
        if (res_free && ((ndue == '0) || last_emit)) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // --- cell commands and result formation ---
  always_comb begin
    ctl           = '0;
    ctl.id        = cmd.timer_id;
    ctl.now       = cmd.now_sec;
    ctl.interval  = cmd.period_sec;
    ctl.loop_flag = cmd.loop_flag;
    ctl.end_new   = arm_sum[SEC_W-1:0];
    ctl.k         = k;
    load_res      = 1'b0;
    act_next      = act_cnt;
    res_next      = '{timer_id_res: cmd.timer_id, status: ST_NONE,
                      active_count: act_cnt, last: 1'b1};
    unique case (state)
      S_IDLE: begin
        if (cmd_fire) begin
          unique case (cmd.operation)
            OP_ARM: begin
              load_res = 1'b1;
              if (!in_range) begin
                res_next.status = ST_NONE;
              end else if (cmd.period_sec == '0) begin
                res_next.status = ST_ZERO;
              end else if (arm_sum[SEC_W]) begin
                res_next.status = ST_OVERFLOW;
              end else begin
                ctl.arm         = 1'b1;
                res_next.status = ST_ARMED;
                if (!any_sel) begin
                  act_next = act_cnt + ACT_W'(1);
                end
              end
            end
            OP_CANCEL: begin
              load_res = 1'b1;
              if (!in_range) begin
                res_next.status = ST_NONE;
              end else if (any_sel) begin
                ctl.cancel      = 1'b1;
                res_next.status = ST_CANCELLED;
                act_next        = act_cnt - ACT_W'(1);
              end else begin
                res_next.status = ST_INACTIVE;
              end
            end
            OP_CHECK: begin
              ctl.load = 1'b1;
            end
            OP_CLEAR: begin
              load_res              = 1'b1;
              ctl.clear             = 1'b1;
              res_next.timer_id_res = '0;
              res_next.status       = ST_NONE;
              act_next              = '0;
            end
            default: ;
          endcase
        end
      end
      S_RANK: begin
        ctl.rank = 1'b1;
      end
      S_EMIT: begin
        if (res_free) begin
          load_res = 1'b1;
          if (ndue == '0) begin
            res_next.timer_id_res = '0;
            res_next.status       = ST_NONE;
          end else begin
            ctl.emit              = 1'b1;
            res_next.timer_id_res = win_id;
            res_next.last         = last_emit;
            if (any_loop) begin
              res_next.status = ST_LOOPED;
            end else begin
              res_next.status = ST_ONCE;
              act_next        = act_cnt - ACT_W'(1);
            end
          end
        end
      end
      default: ;
    endcase
    res_next.active_count = act_next;
  end

  // --- control registers ---
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      res_valid <= 1'b0;
      act_cnt   <= '0;
      step      <= '0;
      k         <= '0;
      ndue      <= '0;
    end else begin
      state   <= state_next;
      act_cnt <= act_next;
      if (load_res) begin
        res_valid <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
      if (ctl.load) begin
        step <= '0;
        ndue <= '0;
        k    <= '0;
      end else begin
        if (ctl.rank) begin
          step <= step + IDX_W'(1);
          // every cell's due mark passes cell 0 once per rotation
          ndue <= ndue + CNT_W'(chain[0].due);
        end
        if (ctl.emit) begin
          k <= k + CNT_W'(1);
        end
      end
    end
  end

  // --- result register ---
  always_ff @(posedge clk) begin
    if (load_res) begin
      res <= res_next;
    end
  end

endmodule

### rtl/dts_checker.sv
// Port-level assertions for the deadline timer scheduler, bound to the top level.
`include "deadline_timer_scheduler_top_macros.svh"

module dts_checker import dts_pkg::*; (
  input logic       clk,
  input logic       rst,
  input logic       cmd_valid,
  input logic       cmd_ready,
  input cmd_item_t  cmd,
  input logic       res_valid,
  input logic       res_ready,
  input res_item_t  res
);

  `DTS_ASSERT_HOLD(a_res_hold, clk, rst, res_valid, res_ready, res)

  `DTS_ASSERT_ALWAYS(a_count_bound, clk, rst,
    !res_valid || (int'(res.active_count) <= MAX_ACTIVE))

  // single-result operations answer in the next cycle
  `DTS_ASSERT_NEXT(a_single_answer, clk, rst,
    cmd_valid && cmd_ready && (cmd.operation != OP_CHECK), res_valid)

  // no new item while a check still owes results
  `DTS_ASSERT_ALWAYS(a_burst_blocks, clk, rst,
    !(res_valid && !res.last) || !cmd_ready)

endmodule

bind deadline_timer_scheduler_top dts_checker u_dts_checker (.*);
